/* rtl/ctfl_pkg.sv */
// ----------------------------------------------------------------------------
// ctfl_pkg
// Shared types and constants of the cache tag lookup with FIFO replacement.
// ----------------------------------------------------------------------------
package ctfl_pkg;

  localparam int unsigned TagW   = 32;
  localparam int unsigned FieldW = 6;
  localparam int unsigned GeoW   = 3;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_SET_BITS    = 2'd1,
    CFG_WAY_BITS    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [TagW-1:0]   tag_value;
    logic [FieldW-1:0] set_index;
    logic [FieldW-1:0] byte_offset;
    logic [FieldW-1:0] line_slot;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [GeoW-1:0]    value;
  } cfg_t;

  // Lookup request broadcast to every line cell.
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [FieldW-1:0] set;
    logic [GeoW-1:0]   wb;
  } cell_req_t;

  // Hit and empty flags, used both for the neighbor chain and per-cell results.
  typedef struct packed {
    logic hit;
    logic empty;
  } line_flags_t;

endpackage

/* rtl/ctfl_chan_if.sv */
// ----------------------------------------------------------------------------
// ctfl_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface ctfl_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ctfl_cell.sv */
// ----------------------------------------------------------------------------
// ctfl_cell
// One cache line: holds valid and tag, compares against the broadcast request
// and passes the hit/empty prefix on to its neighbor.
// ----------------------------------------------------------------------------
module ctfl_cell #(
  parameter int unsigned IDXW = 6,
  parameter int unsigned TAGW = 32,
  parameter int unsigned IDX  = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctfl_pkg::cell_req_t   req_i,
  input  ctfl_pkg::line_flags_t chain_i,
  output ctfl_pkg::line_flags_t chain_o,
  output ctfl_pkg::line_flags_t flag_o,
  input  logic                  wr_i
);
  import ctfl_pkg::*;

  localparam int unsigned CW = (IDXW > FieldW) ? IDXW : FieldW;
  localparam logic [IDXW-1:0] IdxC = IDXW'(IDX);

  logic            valid_q;
  logic [TAGW-1:0] tag_q;
  logic            in_win;
  logic            match;
  logic            empty;
  line_flags_t     flag_d;
  line_flags_t     flag_q;

  assign in_win = (CW'(IdxC >> req_i.wb) == CW'(req_i.set));
  assign match  = in_win && valid_q && (tag_q == req_i.tag[TAGW-1:0]);
  assign empty  = in_win && !valid_q;

  assign flag_d.hit    = match && !chain_i.hit;
  assign flag_d.empty  = empty && !chain_i.empty;
  assign chain_o.hit   = chain_i.hit || match;
  assign chain_o.empty = chain_i.empty || empty;
  assign flag_o        = flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q  <= '0;
    end else begin
      flag_q <= flag_d;
      if (wr_i) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      tag_q <= req_i.tag[TAGW-1:0];
    end
  end

endmodule

/* rtl/ctfl_pick.sv */
// ----------------------------------------------------------------------------
// ctfl_pick
// Scan the eight line groups that cover the set window and register the
// first hit line and the first empty line.
// ----------------------------------------------------------------------------
module ctfl_pick #(
  parameter int unsigned LINES = 64,
  parameter int unsigned IDXW  = 6,
  parameter int unsigned NGRP  = 8,
  parameter int unsigned GW    = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [LINES-1:0]      hit_v_i,
  input  logic [LINES-1:0]      empty_v_i,
  input  logic [GW-1:0]         gbase_i,
  output ctfl_pkg::line_flags_t found_o,
  output logic [IDXW-1:0]       hit_slot_o,
  output logic [IDXW-1:0]       empty_slot_o
);
  import ctfl_pkg::*;

  localparam int unsigned PADW = NGRP * 8;
  localparam int unsigned GXW  = GW + 4;

  function automatic logic [2:0] enc8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      if (v[j]) begin
        r = 3'(j);
      end
    end
    return r;
  endfunction

  logic [PADW-1:0] hv;
  logic [PADW-1:0] ev;
  logic [GXW-1:0]  g;
  logic [GW-1:0]   gs;
  logic [7:0]      hb;
  logic [7:0]      eb;
  line_flags_t     found_d;
  line_flags_t     found_q;
  logic [IDXW-1:0] hit_slot_d;
  logic [IDXW-1:0] empty_slot_d;
  logic [IDXW-1:0] hit_slot_q;
  logic [IDXW-1:0] empty_slot_q;

  always_comb begin
    hv           = PADW'(hit_v_i);
    ev           = PADW'(empty_v_i);
    found_d      = '0;
    hit_slot_d   = '0;
    empty_slot_d = '0;
    g            = '0;
    gs           = '0;
    hb           = '0;
    eb           = '0;
    for (int k = 7; k >= 0; k--) begin
      g = GXW'(gbase_i) + GXW'(k);
      if (g < GXW'(NGRP)) begin
        gs = g[GW-1:0];
        hb = hv[gs*8 +: 8];
        eb = ev[gs*8 +: 8];
        if (|hb) begin
          found_d.hit = 1'b1;
          hit_slot_d  = IDXW'({g, enc8(hb)});
        end
        if (|eb) begin
          found_d.empty = 1'b1;
          empty_slot_d  = IDXW'({g, enc8(eb)});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_slot_q   <= hit_slot_d;
    empty_slot_q <= empty_slot_d;
  end

  assign found_o      = found_q;
  assign hit_slot_o   = hit_slot_q;
  assign empty_slot_o = empty_slot_q;

endmodule

/* rtl/cache_tag_fifo_lookup_core.sv */
// ----------------------------------------------------------------------------
// cache_tag_fifo_lookup_core
// Set-associative tag store with FIFO replacement built from a row of line
// cells; reports hit/miss and the line that holds or receives the tag.
// ----------------------------------------------------------------------------
// Sequence: accept, cell compare, group scan, commit; a new item is accepted
// only in idle, after the commit of the last one, and the commit waits while
// the output register is still occupied.
// Reset: line valid bits and FIFO pointer valid bits clear at once, geometry
// returns to offset 2, set 2, way 1; no clearing pass.
module cache_tag_fifo_lookup_core #(
  parameter int unsigned LINES      = 64,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  ctfl_chan_if.sink   in_if,
  ctfl_chan_if.source out_if,
  ctfl_chan_if.sink   cfg_if
);
  import ctfl_pkg::*;

  localparam int unsigned LG     = $clog2(LINES + 1) - 1;
  localparam int unsigned IDXW   = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned NGRP   = (LINES + 7) / 8;
  localparam int unsigned GW     = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned AW     = (ADDR_WIDTH < TagW) ? ADDR_WIDTH : TagW;
  localparam int unsigned SW     = (LG < FieldW) ? LG : FieldW;
  localparam int unsigned FAW    = (SW > 0) ? SW : 1;
  localparam int unsigned FDEPTH = 1 << FAW;
  localparam int unsigned CW     = (IDXW > FieldW) ? IDXW : FieldW;
  localparam logic [31:0] AMask  = 32'((64'd1 << AW) - 64'd1);
  localparam logic [3:0]  LgC    = 4'(LG);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_PICK,
    ST_COMMIT
  } state_e;

  function automatic logic [GeoW-1:0] sat_geo(input logic [GeoW-1:0] v);
    return (v == 3'd7) ? 3'd6 : v;
  endfunction

  state_e            state_q;
  logic [GeoW-1:0]   offset_bits_q;
  logic [GeoW-1:0]   set_bits_q;
  logic [GeoW-1:0]   way_bits_q;
  logic [GeoW-1:0]   sb_eff;
  logic [GeoW-1:0]   wb_eff;
  logic [3:0]        room;
  logic [31:0]       addr_m;
  cell_req_t         req_d;
  logic [FieldW-1:0] off_d;
  cell_req_t         req_q;
  logic [FieldW-1:0] off_q;
  logic [IDXW-1:0]   base_c;
  logic [GW-1:0]     gbase_c;

  line_flags_t       chain   [LINES+1];
  line_flags_t       flags   [LINES];
  logic [LINES-1:0]  hit_v;
  logic [LINES-1:0]  empty_v;
  logic [LINES-1:0]  wr_vec;

  line_flags_t       found;
  logic [IDXW-1:0]   hit_slot;
  logic [IDXW-1:0]   empty_slot;

  logic [FieldW-1:0] fifo_mem [FDEPTH];
  logic [FDEPTH-1:0] fifo_vld_q;
  logic [FieldW-1:0] fifo_rd_q;
  logic              fifo_rd_vld_q;
  logic [FAW-1:0]    fifo_addr;
  logic              fifo_we;
  logic [FieldW-1:0] fifo_wd;
  logic [FieldW-1:0] wmask;
  logic [FieldW-1:0] ptr;
  logic [IDXW-1:0]   victim;
  logic [IDXW-1:0]   slot_c;
  logic              commit_fire;
  logic              out_vld_q;
  out_t              out_q;

  // Effective geometry
  always_comb begin
    sb_eff = ({1'b0, set_bits_q} > LgC) ? LgC[GeoW-1:0] : set_bits_q;
    room   = LgC - {1'b0, sb_eff};
    wb_eff = ({1'b0, way_bits_q} > room) ? room[GeoW-1:0] : way_bits_q;
  end

  // Address split at the input transfer
  always_comb begin
    addr_m    = in_if.data.address & AMask;
    off_d     = FieldW'(addr_m & ~({32{1'b1}} << offset_bits_q));
    req_d.set = FieldW'((addr_m >> offset_bits_q) & ~({32{1'b1}} << sb_eff));
    req_d.tag = addr_m >> ({1'b0, offset_bits_q} + {1'b0, sb_eff});
    req_d.wb  = wb_eff;
  end

  assign in_if.ready  = (state_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign base_c  = IDXW'(13'(req_q.set) << req_q.wb);
  assign gbase_c = GW'(base_c >> 3);

  // Row of line cells; the prefix chain restarts at every group of eight
  assign chain[0] = '0;
  for (genvar i = 0; i < LINES; i++) begin : g_cell
    line_flags_t chain_in;
    assign chain_in = ((i % 8) == 0) ? line_flags_t'('0) : chain[i];
    ctfl_cell #(
      .IDXW(IDXW),
      .TAGW(AW),
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req_q),
      .chain_i(chain_in),
      .chain_o(chain[i+1]),
      .flag_o (flags[i]),
      .wr_i   (wr_vec[i])
    );
    assign hit_v[i]   = flags[i].hit;
    assign empty_v[i] = flags[i].empty;
    assign wr_vec[i]  = commit_fire && !found.hit && (slot_c == IDXW'(i));
  end

  ctfl_pick #(
    .LINES(LINES),
    .IDXW (IDXW),
    .NGRP (NGRP),
    .GW   (GW)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hit_v_i     (hit_v),
    .empty_v_i   (empty_v),
    .gbase_i     (gbase_c),
    .found_o     (found),
    .hit_slot_o  (hit_slot),
    .empty_slot_o(empty_slot)
  );

  // Replacement choice
  always_comb begin
    wmask   = FieldW'((7'd1 << req_q.wb) - 7'd1);
    ptr     = (fifo_rd_vld_q ? fifo_rd_q : '0) & wmask;
    victim  = base_c | IDXW'(ptr);
    slot_c  = found.hit ? hit_slot : (found.empty ? empty_slot : victim);
    fifo_wd = (ptr + FieldW'(1)) & wmask;
  end

  assign commit_fire = (state_q == ST_COMMIT) && (!out_vld_q || out_if.ready);
  assign fifo_we     = commit_fire && !found.hit && !found.empty;
  assign fifo_addr   = req_q.set[FAW-1:0];

  // FIFO pointer memory
  always_ff @(posedge clk_i) begin
    fifo_rd_q <= fifo_mem[fifo_addr];
    if (fifo_we) begin
      fifo_mem[fifo_addr] <= fifo_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_vld_q    <= '0;
      fifo_rd_vld_q <= 1'b0;
    end else begin
      fifo_rd_vld_q <= fifo_vld_q[fifo_addr];
      if (fifo_we) begin
        fifo_vld_q[fifo_addr] <= 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= 3'd2;
      set_bits_q    <= 3'd2;
      way_bits_q    <= 3'd1;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_idx_e'(cfg_if.data.index))
        CFG_OFFSET_BITS: offset_bits_q <= sat_geo(cfg_if.data.value);
        CFG_SET_BITS:    set_bits_q    <= sat_geo(cfg_if.data.value);
        CFG_WAY_BITS:    way_bits_q    <= sat_geo(cfg_if.data.value);
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      if (commit_fire) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: state_q <= ST_PICK;
        ST_PICK: state_q <= ST_COMMIT;
        ST_COMMIT: begin
          if (commit_fire) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      req_q <= req_d;
      off_q <= off_d;
    end
    if (commit_fire) begin
      out_q.hit         <= found.hit;
      out_q.tag_value   <= req_q.tag;
      out_q.set_index   <= req_q.set;
      out_q.byte_offset <= off_q;
      out_q.line_slot   <= FieldW'(slot_c);
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_vec))
    else $error("more than one line written");

  a_hit_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_fire && found.hit) |-> (wr_vec == '0))
    else $error("line written on a hit");

  a_slot_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_fire |-> (CW'(slot_c >> req_q.wb) == CW'(req_q.set)))
    else $error("chosen line outside the addressed set");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> (state_q == ST_LOOK))
    else $error("transfer did not start a lookup");

  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_fire |=> out_vld_q)
    else $error("commit did not present a result");

endmodule
